// File: rtl/bis_pkg.sv
`default_nettype none

package bis_pkg;

    localparam int TIMER_BITS   = 16;
    localparam int ELAPSED_BITS = TIMER_BITS + 1;
    localparam int CFG_FIELD_BITS = 16;
    localparam int ADDR_BITS    = 4;
    localparam int DATA_BITS    = 32;

    localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;

    localparam logic [TIMER_BITS-1:0] PULSE_ON_RESET  = TIMER_BITS'(100);
    localparam logic [TIMER_BITS-1:0] PULSE_OFF_RESET = TIMER_BITS'(100);
    localparam logic [TIMER_BITS-1:0] NO_FLAME_RESET  = TIMER_BITS'(5000);

    typedef enum logic [1:0] {
        REG_PULSE_ON  = 2'd0,
        REG_PULSE_OFF = 2'd1,
        REG_NO_FLAME  = 2'd2,
        REG_UNUSED    = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        STAT_OFF      = 2'd0,
        STAT_IGNITING = 2'd1,
        STAT_BURNING  = 2'd2,
        STAT_LOCKOUT  = 2'd3
    } status_t;

    function automatic logic [TIMER_BITS-1:0] cfg_from_word(input logic [DATA_BITS-1:0] w);
        logic [CFG_FIELD_BITS-1:0] field;
        field = w[CFG_FIELD_BITS-1:0];
        return TIMER_BITS'(field);
    endfunction

    function automatic logic [ELAPSED_BITS-1:0] sat_inc(input logic [ELAPSED_BITS-1:0] v);
        return (v == ELAPSED_MAX) ? ELAPSED_MAX : v + ELAPSED_BITS'(1);
    endfunction

endpackage

`default_nettype wire

// File: rtl/burner_ignition_supervisor.sv
// Gas burner ignition supervisor, one request per millisecond tick.
// Input channel (in_valid/in_ready) carries heat_request and flame_sensed
// for one tick. Output channel (out_valid/out_ready) returns gas_valve,
// igniter_drive and burner_status for that tick, one result per request,
// in order.
// Latency: the result is valid the cycle after the request is accepted.
// Throughput: one request per cycle; the whole tick update (saturating
// elapsed counters, supervisor decision, igniter pulse counter) is a
// single pass of logic between the state registers and the result register.
// When the receiver stalls, the result register holds and in_ready drops
// until the result is taken; in_ready follows out_ready in the same cycle,
// so a full result register never blocks a simultaneous take-and-accept.
// Reset (rst_n low, asynchronous) closes the burner, clears the lockout
// flag and counters, empties the result register and loads the timing
// registers with 100 / 100 / 5000 ticks. The APB port writes pulse_on_ticks
// (0x0), pulse_off_ticks (0x4) and no_flame_ticks (0x8); pready is always
// high and reads return the stored value. Write registers only while idle.
`default_nettype none

module burner_ignition_supervisor (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bis_pkg::ADDR_BITS-1:0]  paddr,
    input  wire logic [bis_pkg::DATA_BITS-1:0]  pwdata,
    output logic      [bis_pkg::DATA_BITS-1:0]  prdata,
    output logic                                pready,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           heat_request,
    input  wire logic                           flame_sensed,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                gas_valve,
    output logic                                igniter_drive,
    output logic      [1:0]                     burner_status
);
    import bis_pkg::*;

    logic [TIMER_BITS-1:0]   pulse_on_reg;
    logic [TIMER_BITS-1:0]   pulse_off_reg;
    logic [TIMER_BITS-1:0]   no_flame_reg;

    logic                    burner_on_reg,       burner_on_next;
    logic                    failed_reg,          failed_next;
    logic                    ign_en_reg,          ign_en_next;
    logic [ELAPSED_BITS-1:0] ign_elapsed_reg,     ign_elapsed_next;
    logic [ELAPSED_BITS-1:0] lock_elapsed_reg,    lock_elapsed_next;
    logic [TIMER_BITS-1:0]   pulse_cnt_reg,       pulse_cnt_next;
    logic                    on_phase_reg,        on_phase_next;

    logic                    out_valid_reg;
    logic                    gas_reg,             gas_next;
    logic                    spark_reg,           spark_next;
    status_t                 status_reg,          status_next;

    logic                    accept;
    logic                    cfg_write;
    reg_index_t              cfg_sel;
    logic [ELAPSED_BITS-1:0] nf_ext;
    logic [TIMER_BITS:0]     cnt_inc;

    assign pready    = 1'b1;
    assign cfg_sel   = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pulse_on_reg  <= PULSE_ON_RESET;
            pulse_off_reg <= PULSE_OFF_RESET;
            no_flame_reg  <= NO_FLAME_RESET;
        end else if (cfg_write) begin
            unique case (cfg_sel)
                REG_PULSE_ON:  pulse_on_reg  <= cfg_from_word(pwdata);
                REG_PULSE_OFF: pulse_off_reg <= cfg_from_word(pwdata);
                REG_NO_FLAME:  no_flame_reg  <= cfg_from_word(pwdata);
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_PULSE_ON:  prdata = DATA_BITS'(pulse_on_reg);
            REG_PULSE_OFF: prdata = DATA_BITS'(pulse_off_reg);
            REG_NO_FLAME:  prdata = DATA_BITS'(no_flame_reg);
            default:       prdata = '0;
        endcase
    end

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign nf_ext   = ELAPSED_BITS'(no_flame_reg);

    // One tick: advance timers, supervise, then run the pulse generator.
    always_comb begin
        burner_on_next    = burner_on_reg;
        failed_next       = failed_reg;
        ign_en_next       = ign_en_reg;
        ign_elapsed_next  = sat_inc(ign_elapsed_reg);
        lock_elapsed_next = sat_inc(lock_elapsed_reg);
        pulse_cnt_next    = pulse_cnt_reg;
        on_phase_next     = on_phase_reg;
        spark_next        = 1'b0;
        cnt_inc           = '0;

        if (!heat_request) begin
            if (burner_on_reg) begin
                burner_on_next = 1'b0;
                failed_next    = 1'b0;
                ign_en_next    = 1'b0;
            end
        end else if (!(failed_reg && lock_elapsed_next < nf_ext)) begin
            if (!burner_on_reg) begin
                failed_next      = 1'b0;
                burner_on_next   = 1'b1;
                ign_en_next      = 1'b1;
                ign_elapsed_next = '0;
            end
            if (flame_sensed) begin
                ign_en_next = 1'b0;
                failed_next = 1'b0;
            end else if (ign_en_next && ign_elapsed_next >= nf_ext) begin
                failed_next       = 1'b1;
                ign_en_next       = 1'b0;
                burner_on_next    = 1'b0;
                lock_elapsed_next = '0;
            end else if (!ign_en_next && ign_elapsed_next > nf_ext) begin
                ign_en_next      = 1'b1;
                ign_elapsed_next = '0;
            end
        end

        if (!ign_en_next) begin
            // Drop the spark now and rewind to the start of an on phase.
            pulse_cnt_next = '0;
            on_phase_next  = 1'b1;
        end else begin
            spark_next = on_phase_reg;
            cnt_inc    = {1'b0, pulse_cnt_reg} + (TIMER_BITS+1)'(1);
            pulse_cnt_next = cnt_inc[TIMER_BITS-1:0];
            if (on_phase_reg) begin
                if (cnt_inc >= {1'b0, pulse_on_reg}) begin
                    pulse_cnt_next = '0;
                    if (pulse_off_reg != '0)
                        on_phase_next = 1'b0;
                end
            end else if (cnt_inc >= {1'b0, pulse_off_reg}) begin
                pulse_cnt_next = '0;
                on_phase_next  = 1'b1;
            end
        end

        gas_next = burner_on_next;
        if (!burner_on_next)
            status_next = failed_next ? STAT_LOCKOUT : STAT_OFF;
        else
            status_next = ign_en_next ? STAT_IGNITING : STAT_BURNING;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            burner_on_reg    <= 1'b0;
            failed_reg       <= 1'b0;
            ign_en_reg       <= 1'b0;
            ign_elapsed_reg  <= '0;
            lock_elapsed_reg <= '0;
            pulse_cnt_reg    <= '0;
            on_phase_reg     <= 1'b1;
            out_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                burner_on_reg    <= burner_on_next;
                failed_reg       <= failed_next;
                ign_en_reg       <= ign_en_next;
                ign_elapsed_reg  <= ign_elapsed_next;
                lock_elapsed_reg <= lock_elapsed_next;
                pulse_cnt_reg    <= pulse_cnt_next;
                on_phase_reg     <= on_phase_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            gas_reg    <= gas_next;
            spark_reg  <= spark_next;
            status_reg <= status_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign gas_valve     = gas_reg;
    assign igniter_drive = spark_reg;
    assign burner_status = status_reg;

endmodule

`default_nettype wire

// File: rtl/bis_checker.sv
`default_nettype none

module bis_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       gas_valve,
    input wire logic       igniter_drive,
    input wire logic [1:0] burner_status
);
    import bis_pkg::*;

    // A stalled result holds.
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(gas_valve)
            && $stable(igniter_drive) && $stable(burner_status))
        else $error("stalled result changed");

    // An empty result register never blocks a request.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with empty result register");

    // Gas is open exactly in the igniting and burning states.
    a_gas_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> gas_valve == (burner_status == STAT_IGNITING
            || burner_status == STAT_BURNING))
        else $error("gas valve disagrees with status");

    // Spark only while igniting.
    a_spark_only_igniting: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && igniter_drive |-> burner_status == STAT_IGNITING)
        else $error("igniter active outside igniting state");

endmodule

bind burner_ignition_supervisor bis_checker u_bis_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .gas_valve     (gas_valve),
    .igniter_drive (igniter_drive),
    .burner_status (burner_status)
);

`default_nettype wire

// File: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bis_pkg::*;

    localparam int RUN_LIMIT   = 200_000;
    localparam int PHASE_TICKS = 50;

    typedef struct packed {
        logic heat;
        logic flame;
    } tick_t;

    typedef struct packed {
        logic    gas;
        logic    spark;
        status_t status;
    } burner_out_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [DATA_BITS-1:0] pwdata = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 heat_request = 1'b0;
    logic                 flame_sensed = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 gas_valve;
    logic                 igniter_drive;
    logic [1:0]           burner_status;

    burner_ignition_supervisor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .heat_request  (heat_request),
        .flame_sensed  (flame_sensed),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .gas_valve     (gas_valve),
        .igniter_drive (igniter_drive),
        .burner_status (burner_status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Timing registers as the block should hold them
    logic [TIMER_BITS-1:0] t_on       = PULSE_ON_RESET;
    logic [TIMER_BITS-1:0] t_off      = PULSE_OFF_RESET;
    logic [TIMER_BITS-1:0] t_no_flame = NO_FLAME_RESET;

    // Burner state as the block should hold it
    logic                    sim_on        = 1'b0;
    logic                    sim_failed    = 1'b0;
    logic                    sim_arm       = 1'b0;
    logic [ELAPSED_BITS-1:0] sim_ign_age   = '0;
    logic [ELAPSED_BITS-1:0] sim_lock_age  = '0;
    logic [TIMER_BITS-1:0]   sim_pulse_cnt = '0;
    logic                    sim_pulse_hi  = 1'b1;

    tick_t       tick_queue[$];
    burner_out_t expected_outputs[$];

    int ticks_queued  = 0;
    int ticks_checked = 0;
    int cfg_writes    = 0;
    int mismatches    = 0;
    int gas_ticks     = 0;
    int spark_ticks   = 0;
    int lockout_ticks = 0;
    int cycle_count   = 0;

    int burst_left = 0;
    int gap_left   = 0;
    int rx_step    = 0;
    int rx_period  = 4;
    int rx_busy    = 0;

    function automatic burner_out_t advance_burner(input logic heat, input logic flame);
        logic [TIMER_BITS:0] next_cnt;
        burner_out_t         r;
        sim_ign_age  = (sim_ign_age == '1) ? sim_ign_age : sim_ign_age + ELAPSED_BITS'(1);
        sim_lock_age = (sim_lock_age == '1) ? sim_lock_age : sim_lock_age + ELAPSED_BITS'(1);

        if (!heat)
        begin
            // only a running burner is shut; a lockout already in force stays
            if (sim_on)
            begin
                sim_on     = 1'b0;
                sim_failed = 1'b0;
                sim_arm    = 1'b0;
            end
        end
        else if (!(sim_failed && sim_lock_age < ELAPSED_BITS'(t_no_flame)))
        begin
            if (!sim_on)
            begin
                sim_failed  = 1'b0;
                sim_on      = 1'b1;
                sim_arm     = 1'b1;
                sim_ign_age = '0;
            end
            if (flame)
            begin
                sim_arm    = 1'b0;
                sim_failed = 1'b0;
            end
            else if (sim_arm && sim_ign_age >= ELAPSED_BITS'(t_no_flame))
            begin
                sim_failed   = 1'b1;
                sim_arm      = 1'b0;
                sim_on       = 1'b0;
                sim_lock_age = '0;
            end
            else if (!sim_arm && sim_ign_age > ELAPSED_BITS'(t_no_flame))
            begin
                // flame lost while burning: re-arm with gas still open
                sim_arm     = 1'b1;
                sim_ign_age = '0;
            end
        end

        r.spark = 1'b0;
        if (!sim_arm)
        begin
            sim_pulse_cnt = '0;
            sim_pulse_hi  = 1'b1;
        end
        else
        begin
            r.spark  = sim_pulse_hi;
            next_cnt = {1'b0, sim_pulse_cnt} + (TIMER_BITS+1)'(1);
            if (sim_pulse_hi)
            begin
                if (next_cnt >= {1'b0, t_on})
                begin
                    next_cnt = '0;
                    if (t_off != '0)
                        sim_pulse_hi = 1'b0;
                end
            end
            else if (next_cnt >= {1'b0, t_off})
            begin
                next_cnt     = '0;
                sim_pulse_hi = 1'b1;
            end
            sim_pulse_cnt = next_cnt[TIMER_BITS-1:0];
        end

        r.gas = sim_on;
        if (!sim_on)
            r.status = sim_failed ? STAT_LOCKOUT : STAT_OFF;
        else
            r.status = sim_arm ? STAT_IGNITING : STAT_BURNING;
        return r;
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $error("%s: expected %0h, got %0h", what, want, got);
        end
    endfunction

    // Tick driver: bursts of requests separated by random gaps
    always @(posedge clk)
    begin
        tick_t t;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_outputs.push_back(advance_burner(heat_request, flame_sensed));
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (tick_queue.size() > 0)
                begin
                    t = tick_queue.pop_front();
                    in_valid     <= 1'b1;
                    heat_request <= t.heat;
                    flame_sensed <= t.flame;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(4, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor; the receiver holds out_ready low at the start of each period while rx_step is below rx_busy
    always @(posedge clk)
    begin
        burner_out_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_outputs.size() == 0)
                begin
                    mismatches++;
                    $error("burner_status: result with no tick pending, got %0d", burner_status);
                end
                else
                begin
                    want = expected_outputs.pop_front();
                    check_field("gas_valve", 32'(want.gas), 32'(gas_valve));
                    check_field("igniter_drive", 32'(want.spark), 32'(igniter_drive));
                    check_field("burner_status", 32'(want.status), 32'(burner_status));
                    ticks_checked++;
                    gas_ticks     += int'(gas_valve);
                    spark_ticks   += int'(igniter_drive);
                    lockout_ticks += int'(burner_status == STAT_LOCKOUT);
                end
            end
            if (rx_step + 1 >= rx_period)
            begin
                rx_step = 0;
                if ($urandom_range(0, 3) == 0)
                begin
                    rx_period = $urandom_range(2, 8);
                    rx_busy   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, rx_period - 1);
                end
            end
            else
            begin
                rx_step++;
            end
            out_ready <= (rx_step >= rx_busy);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d ticks still expected",
                     cycle_count, expected_outputs.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic queue_ticks(input logic heat, input logic flame, input int n);
        repeat (n)
        begin
            tick_queue.push_back({heat, flame});
            ticks_queued++;
        end
    endtask

    // Hold until every queued tick has been answered, then let the pipe settle
    task automatic drain();
        do
            @(posedge clk);
        while (tick_queue.size() != 0 || in_valid || expected_outputs.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_timing(input reg_index_t idx, input logic [15:0] val);
        logic [31:0]           junk;
        logic [TIMER_BITS-1:0] stored;
        junk   = $urandom;
        stored = TIMER_BITS'(val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'({idx, 2'b00});
        pwdata  <= {junk[15:0], val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        cfg_writes++;
        case (idx)
            REG_PULSE_ON:  t_on = stored;
            REG_PULSE_OFF: t_off = stored;
            REG_NO_FLAME:  t_no_flame = stored;
            default: ;
        endcase
        if (idx == REG_UNUSED)
        begin
            psel    <= 1'b0;
            penable <= 1'b0;
        end
        else
        begin
            // read back from the same address
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            check_field("prdata", DATA_BITS'(stored), prdata);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    initial
    begin
        int          phase;
        int          span;
        int          goal;
        logic [15:0] on_v;
        logic [15:0] off_v;
        logic [15:0] nf_v;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset timing: off, igniting, burning, flame gone, request dropped
        queue_ticks(1'b0, 1'b0, 1);
        queue_ticks(1'b1, 1'b0, 2);
        queue_ticks(1'b1, 1'b1, 1);
        queue_ticks(1'b1, 1'b0, 1);
        queue_ticks(1'b0, 1'b1, 1);
        drain();

        // zero timeout, zero on time, steady igniter
        program_timing(REG_PULSE_ON, 16'd0);
        program_timing(REG_PULSE_OFF, 16'd0);
        program_timing(REG_NO_FLAME, 16'd0);
        program_timing(REG_UNUSED, 16'hFFFF);
        queue_ticks(1'b1, 1'b0, 2);
        queue_ticks(1'b0, 1'b0, 1);
        queue_ticks(1'b1, 1'b1, 1);
        queue_ticks(1'b1, 1'b0, 1);
        drain();

        // timeout, lockout held across a dropped request, retry, flame loss
        program_timing(REG_PULSE_ON, 16'd2);
        program_timing(REG_PULSE_OFF, 16'd1);
        program_timing(REG_NO_FLAME, 16'd3);
        queue_ticks(1'b1, 1'b0, 5);
        queue_ticks(1'b0, 1'b1, 2);
        queue_ticks(1'b1, 1'b0, 1);
        queue_ticks(1'b1, 1'b1, 2);
        queue_ticks(1'b1, 1'b0, 4);
        queue_ticks(1'b0, 1'b0, 1);
        drain();

        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:
                begin
                    on_v  = 16'hFFFF;
                    off_v = 16'hFFFF;
                    nf_v  = 16'hFFFF;
                end
                1:
                begin
                    on_v  = 16'hFFFF;
                    off_v = 16'd0;
                    nf_v  = 16'd12;
                end
                default:
                begin
                    on_v  = 16'($urandom_range(0, 5));
                    off_v = 16'($urandom_range(0, 5));
                    nf_v  = 16'(($urandom_range(0, 4) == 0) ? $urandom_range(41, 65535)
                                                            : $urandom_range(0, 25));
                end
            endcase
            program_timing(REG_PULSE_ON, on_v);
            program_timing(REG_PULSE_OFF, off_v);
            program_timing(REG_NO_FLAME, nf_v);
            span = (t_no_flame > 40) ? 40 : int'(t_no_flame);
            goal = ticks_queued + PHASE_TICKS;
            while (ticks_queued < goal)
            begin
                case ($urandom_range(0, 5))
                    0:
                    begin
                        queue_ticks(1'b1, 1'b0, $urandom_range(0, span + 2));
                        queue_ticks(1'b1, 1'b1, $urandom_range(1, 15));
                    end
                    1: queue_ticks(1'b1, 1'b0, span + $urandom_range(1, span + 5));
                    2:
                    begin
                        queue_ticks(1'b1, 1'b1, $urandom_range(1, span + 5));
                        queue_ticks(1'b1, 1'b0, $urandom_range(1, 2 * span + 4));
                    end
                    3: queue_ticks(1'b0, 1'($urandom_range(0, 1)), $urandom_range(1, 8));
                    4:
                    begin
                        repeat ($urandom_range(1, 10))
                            queue_ticks(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1);
                    end
                    default:
                    begin
                        queue_ticks(1'b1, 1'b0, span + 1);
                        queue_ticks(1'b0, 1'($urandom_range(0, 1)), $urandom_range(1, span + 1));
                        queue_ticks(1'b1, 1'($urandom_range(0, 1)), $urandom_range(1, span + 3));
                    end
                endcase
            end
            drain();
        end

        $display("%0d burner ticks checked after %0d timing register writes",
                 ticks_checked, cfg_writes);
        $display("gas open on %0d ticks, igniter sparking on %0d, lockout shown on %0d",
                 gas_ticks, spark_ticks, lockout_ticks);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
